// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants of the CRC-framed packet parser.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Parse phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CRC     = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_DATA        = 3'd0;
  localparam logic [2:0] KIND_GOOD        = 3'd1;
  localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] KIND_BAD_VERSION = 3'd3;
  localparam logic [2:0] KIND_TOO_LARGE   = 3'd4;
  localparam logic [2:0] KIND_CRC_BAD     = 3'd5;

  // Header byte offsets
  localparam logic [15:0] HDR_MAGIC_END   = 16'd4;
  localparam logic [15:0] HDR_VERSION     = 16'd4;
  localparam logic [15:0] HDR_TYPE        = 16'd5;
  localparam logic [15:0] HDR_SEQ_LO      = 16'd8;
  localparam logic [15:0] HDR_SEQ_HI      = 16'd9;
  localparam logic [15:0] HDR_LEN_LO      = 16'd10;
  localparam logic [15:0] HDR_LEN_HI      = 16'd11;

  // Modbus CRC-16
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register indexes
  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  // One result item from the parser core
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [7:0]  msg_type;
    logic [15:0] sequence_num;
    logic [15:0] length;
    logic        frame_end;
  } res_t;

endpackage

// ===== rtl/cpp_crc16.sv =====
// ----------------------------------------------------------------------------
// cpp_crc16
// One-byte update of the Modbus CRC-16, unrolled over the eight bit steps.
// ----------------------------------------------------------------------------
module cpp_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import cpp_pkg::*;

  // Shift out eight bits, folding in the polynomial on each set lsb
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/cpp_parser.sv =====
// ----------------------------------------------------------------------------
// cpp_parser
// Frame state and per-byte parse logic: header checks, payload pass-through,
// CRC compare and verdicts.
// ----------------------------------------------------------------------------
module cpp_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    in_byte,
  input  logic [31:0]   frame_magic,
  input  logic [7:0]    frame_version,
  output cpp_pkg::res_t res
);
  import cpp_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  type_hold, type_hold_next;
  logic [15:0] seq_hold, seq_hold_next;
  logic [15:0] len_hold, len_hold_next;
  logic [7:0]  crc_low, crc_low_next;

  logic [15:0] crc_fed;
  logic [15:0] len_full;
  logic        restart;

  cpp_crc16 u_crc (
    .crc_in  (crc_acc),
    .data_in (in_byte),
    .crc_out (crc_fed)
  );

  assign len_full = len_hold | {in_byte, 8'h00};

  // Next state and result for the byte at hand
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    crc_acc_next   = crc_acc;
    type_hold_next = type_hold;
    seq_hold_next  = seq_hold;
    len_hold_next  = len_hold;
    crc_low_next   = crc_low;
    restart        = 1'b0;
    res.valid      = 1'b0;
    res.kind       = KIND_DATA;
    res.data       = 8'h00;
    res.frame_end  = 1'b0;

    unique case (phase)
      PH_PAYLOAD: begin
        crc_acc_next = crc_fed;
        res.valid    = 1'b1;
        res.data     = in_byte;
        if ({1'b0, pos} + 17'd1 >= {1'b0, len_hold}) begin
          phase_next = PH_CRC;
          pos_next   = 16'd0;
        end else begin
          pos_next = pos + 16'd1;
        end
      end
      PH_CRC: begin
        if (pos == 16'd0) begin
          crc_low_next = in_byte;
          pos_next     = 16'd1;
        end else begin
          res.valid     = 1'b1;
          res.frame_end = 1'b1;
          res.kind      = ({in_byte, crc_low} == crc_acc) ? KIND_GOOD : KIND_CRC_BAD;
          restart       = 1'b1;
        end
      end
      default: begin
        // header phase; the unused code behaves the same
        crc_acc_next = crc_fed;
        pos_next     = pos + 16'd1;
        if (pos < HDR_MAGIC_END) begin
          if (frame_magic[{pos[1:0], 3'b000} +: 8] != in_byte) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD_MAGIC;
          end
        end else if (pos == HDR_VERSION) begin
          if (in_byte != frame_version) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD_VERSION;
          end
        end else if (pos == HDR_TYPE) begin
          type_hold_next = in_byte;
        end else if (pos == HDR_SEQ_LO) begin
          seq_hold_next = {8'h00, in_byte};
        end else if (pos == HDR_SEQ_HI) begin
          seq_hold_next = seq_hold | {in_byte, 8'h00};
        end else if (pos == HDR_LEN_LO) begin
          len_hold_next = {8'h00, in_byte};
        end else if (pos >= HDR_LEN_HI) begin
          len_hold_next = len_full;
          pos_next      = 16'd0;
          if ({1'b0, len_full} > 17'(MAX_PAYLOAD)) begin
            res.valid = 1'b1;
            res.kind  = KIND_TOO_LARGE;
          end else begin
            phase_next = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        if (res.valid) begin
          res.frame_end = 1'b1;
          restart       = 1'b1;
        end
      end
    endcase

    // Holds as seen by the result, before any restart
    res.msg_type     = type_hold_next;
    res.sequence_num = seq_hold_next;
    res.length       = len_hold_next;

    // Drop the frame after a verdict
    if (restart) begin
      phase_next     = PH_HEADER;
      pos_next       = 16'd0;
      crc_acc_next   = CRC_INIT;
      type_hold_next = 8'h00;
      seq_hold_next  = 16'h0000;
      len_hold_next  = 16'h0000;
      crc_low_next   = 8'h00;
    end
  end

  // Advance frame state on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= 16'd0;
      crc_acc   <= CRC_INIT;
      type_hold <= 8'h00;
      seq_hold  <= 16'h0000;
      len_hold  <= 16'h0000;
      crc_low   <= 8'h00;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      crc_acc   <= crc_acc_next;
      type_hold <= type_hold_next;
      seq_hold  <= seq_hold_next;
      len_hold  <= len_hold_next;
      crc_low   <= crc_low_next;
    end
  end

endmodule

// ===== rtl/crc_framed_packet_parser.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_parser
// Byte-serial parser for length-prefixed frames checked by Modbus CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries one received byte
//   per item. The master stream carries results: payload bytes as they
//   arrive (m_tuser = 0, m_tlast = 0) and one verdict per frame attempt
//   (m_tuser = good, bad magic, bad version, too large or CRC mismatch,
//   m_tlast = 1). The first CRC byte and header bytes that pass give no result.
//   The expected magic and version are written through cfg_we/cfg_index/
//   cfg_data while the block is idle.
//   The byte lands in the input register at the accepting edge, and the parse
//   logic and CRC byte update load the output register when the byte advances
//   out of it. One byte is taken every cycle while the output is not stalled;
//   the per-byte CRC network and the frame state update are combinational.
//   When the receiver stalls, the output register holds its item, the input
//   register takes one more byte, and then s_tready drops until the output
//   drains. Reset clears both registers' valid flags, the frame state (next
//   byte is header byte 0, CRC back to 0xFFFF) and the magic and version registers.
// ----------------------------------------------------------------------------
module crc_framed_packet_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] data_byte, [15:8] msg_type,
                                 // [31:16] frame_sequence, [47:32] payload_length
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast,   // frame_end
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import cpp_pkg::*;

  logic [31:0] frame_magic;
  logic [7:0]  frame_version;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  res_t        res;

  // Move an item out of the input register when the output can take it
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic   <= 32'h0;
      frame_version <= 8'h0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:   frame_magic   <= cfg_data;
        CFG_VERSION: frame_version <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  cpp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .in_byte       (in_byte),
    .frame_magic   (frame_magic),
    .frame_version (frame_version),
    .res           (res)
  );

  // Output register: load on advance, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.length, res.sequence_num, res.msg_type, res.data};
      m_tuser <= res.kind;
      m_tlast <= res.frame_end;
    end
  end

endmodule
